>>> design/aat_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the box affine transform block.
// Depends on nothing; used by aat_cfg_if, aabb_affine_transform and the testbench.

package aat_pkg;

  localparam int NUM_AXES    = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int COEF_INT_W  = 4;
  localparam int REG_WORD_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROW_X   = 3'd0,
    CFG_ROW_Y   = 3'd1,
    CFG_ROW_Z   = 3'd2,
    CFG_SHIFT_X = 3'd3,
    CFG_SHIFT_Y = 3'd4,
    CFG_SHIFT_Z = 3'd5
  } cfg_index_t;

endpackage

>>> design/aat_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on aat_pkg for the index width.

interface aat_cfg_if #(
  parameter int DATA_WIDTH = 48
);
  logic                              valid;
  logic                              ready;
  logic [aat_pkg::CFG_INDEX_W-1:0]   index;
  logic [DATA_WIDTH-1:0]             data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/aat_box_if.sv
`timescale 1ns / 1ps
// Input channel carrying one axis-aligned box per transfer.
// No dependencies.

interface aat_box_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] lo_x;
  logic signed [COORD_WIDTH-1:0] lo_y;
  logic signed [COORD_WIDTH-1:0] lo_z;
  logic signed [COORD_WIDTH-1:0] hi_x;
  logic signed [COORD_WIDTH-1:0] hi_y;
  logic signed [COORD_WIDTH-1:0] hi_z;
  logic                          box_ok;

  modport source (output valid, output lo_x, output lo_y, output lo_z, output hi_x,
                  output hi_y, output hi_z, output box_ok, input ready);
  modport sink   (input valid, input lo_x, input lo_y, input lo_z, input hi_x,
                  input hi_y, input hi_z, input box_ok, output ready);
endinterface

>>> design/aat_bound_if.sv
`timescale 1ns / 1ps
// Output channel carrying one transformed bounding box per transfer.
// No dependencies.

interface aat_bound_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_lo_x;
  logic signed [COORD_WIDTH-1:0] out_lo_y;
  logic signed [COORD_WIDTH-1:0] out_lo_z;
  logic signed [COORD_WIDTH-1:0] out_hi_x;
  logic signed [COORD_WIDTH-1:0] out_hi_y;
  logic signed [COORD_WIDTH-1:0] out_hi_z;
  logic                          out_ok;
  logic                          clipped;

  modport source (output valid, output out_lo_x, output out_lo_y, output out_lo_z,
                  output out_hi_x, output out_hi_y, output out_hi_z, output out_ok,
                  output clipped, input ready);
  modport sink   (input valid, input out_lo_x, input out_lo_y, input out_lo_z,
                  input out_hi_x, input out_hi_y, input out_hi_z, input out_ok,
                  input clipped, output ready);
endinterface

>>> design/aat_clamp.sv
`timescale 1ns / 1ps
// Floor right shift of a wide corner value and saturation to the coordinate range.
// No dependencies; used by aabb_affine_transform.

module aat_clamp #(
  parameter int COORD_WIDTH = 24,
  parameter int ACC_WIDTH   = 44,
  parameter int SHIFT       = 13
) (
  input  logic signed [ACC_WIDTH-1:0]   value,
  output logic signed [COORD_WIDTH-1:0] result,
  output logic                          clip
);

  logic signed [ACC_WIDTH-1:0]        shifted;
  logic [ACC_WIDTH-COORD_WIDTH:0]     top_bits;
  logic                               fits;

  assign shifted  = value >>> SHIFT;
  assign top_bits = shifted[ACC_WIDTH-1:COORD_WIDTH-1];
  assign fits     = (&top_bits) || !(|top_bits);
  assign clip     = !fits;

  always_comb begin
    if (fits) begin
      result = shifted[COORD_WIDTH-1:0];
    end else if (shifted[ACC_WIDTH-1]) begin
      result = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      result = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  end

endmodule

>>> design/aabb_affine_transform.sv
`timescale 1ns / 1ps
// Top level of the box affine transform: configuration registers and the pipeline.
// Depends on aat_pkg, the aat_*_if interfaces and aat_clamp.
//
// Each transfer on the box channel carries the min and max corners of an
// axis-aligned box and a valid flag. One transfer on the bound channel returns
// the tight axis-aligned box around its image under the affine transform held
// in six configuration registers (three matrix rows, three translations).
// The configuration channel is always ready; write it only while the pipeline
// is empty. Writes to an index above the register list are dropped.
// The datapath has four register stages: corner sum and difference, the
// eighteen coefficient products, the three-term sums, and the shifted and
// saturated output register. A new box can be accepted at every edge while
// box.ready is high, so the rate is one box per cycle unless the output stalls.
// When the receiver holds ready low, the full stages hold their contents and
// box.ready drops once every stage is occupied; empty stages still fill.
// Reset empties the pipeline and loads the identity matrix and zero translation.

module aabb_affine_transform #(
  parameter int COORD_WIDTH = 24,
  parameter int COEF_WIDTH  = 16
) (
  input  logic               clk,
  input  logic               rst,
  aat_cfg_if.sink            cfg,
  aat_box_if.sink            box,
  aat_bound_if.source        bound
);

  localparam int AXES      = aat_pkg::NUM_AXES;
  localparam int COEF_FRAC = COEF_WIDTH - aat_pkg::COEF_INT_W;
  localparam int ROW_W     = 3 * COEF_WIDTH;
  localparam int PROD_W    = COORD_WIDTH + 1 + COEF_WIDTH;
  localparam int ACC_W     = COORD_WIDTH + COEF_WIDTH + 4;
  localparam int STAGES    = 4;

  logic [ROW_W-1:0]              rows   [AXES];
  logic signed [COORD_WIDTH-1:0] shifts [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        rows[i]   <= ROW_W'(1) << (i * COEF_WIDTH + COEF_FRAC);
        shifts[i] <= '0;
      end
    end else if (cfg.valid) begin
      unique case (cfg.index)
        aat_pkg::CFG_ROW_X:   rows[0]   <= cfg.data[ROW_W-1:0];
        aat_pkg::CFG_ROW_Y:   rows[1]   <= cfg.data[ROW_W-1:0];
        aat_pkg::CFG_ROW_Z:   rows[2]   <= cfg.data[ROW_W-1:0];
        aat_pkg::CFG_SHIFT_X: shifts[0] <= cfg.data[COORD_WIDTH-1:0];
        aat_pkg::CFG_SHIFT_Y: shifts[1] <= cfg.data[COORD_WIDTH-1:0];
        aat_pkg::CFG_SHIFT_Z: shifts[2] <= cfg.data[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // Coefficient bits that lie beyond the 64-bit register word read as zero.
  logic signed [COEF_WIDTH-1:0] coef     [AXES][AXES];
  logic [COEF_WIDTH-1:0]        coef_mag [AXES][AXES];

  for (genvar i = 0; i < AXES; i++) begin : g_row
    for (genvar j = 0; j < AXES; j++) begin : g_col
      for (genvar k = 0; k < COEF_WIDTH; k++) begin : g_bit
        if (j * COEF_WIDTH + k < aat_pkg::REG_WORD_W) begin : g_in
          assign coef[i][j][k] = rows[i][j*COEF_WIDTH+k];
        end else begin : g_out
          assign coef[i][j][k] = 1'b0;
        end
      end
      assign coef_mag[i][j] = coef[i][j][COEF_WIDTH-1] ? (~coef[i][j] + 1'b1) : coef[i][j];
    end
  end

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] rdy;

  assign rdy[STAGES-1] = !vld[STAGES-1] || bound.ready;
  for (genvar s = 0; s < STAGES - 1; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end
  assign box.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= box.valid;
      end
      for (int s = 1; s < STAGES; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  logic signed [COORD_WIDTH-1:0] in_lo [AXES];
  logic signed [COORD_WIDTH-1:0] in_hi [AXES];

  assign in_lo[0] = box.lo_x;
  assign in_lo[1] = box.lo_y;
  assign in_lo[2] = box.lo_z;
  assign in_hi[0] = box.hi_x;
  assign in_hi[1] = box.hi_y;
  assign in_hi[2] = box.hi_z;

  logic signed [COORD_WIDTH:0] in_diff [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      in_diff[i] = (COORD_WIDTH+1)'(in_hi[i]) - (COORD_WIDTH+1)'(in_lo[i]);
    end
  end

  // Stage 1: doubled center and doubled half-size magnitude.
  logic                        s1_ok;
  logic signed [COORD_WIDTH:0] s1_cen [AXES];
  logic [COORD_WIDTH:0]        s1_ext [AXES];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_ok <= box.box_ok;
      for (int i = 0; i < AXES; i++) begin
        s1_cen[i] <= (COORD_WIDTH+1)'(in_hi[i]) + (COORD_WIDTH+1)'(in_lo[i]);
        s1_ext[i] <= in_diff[i][COORD_WIDTH] ? (~in_diff[i] + 1'b1) : in_diff[i];
      end
    end
  end

  // Stage 2: products with the matrix and its element-wise magnitude.
  logic                     s2_ok;
  logic signed [PROD_W-1:0] s2_cp [AXES][AXES];
  logic [PROD_W-1:0]        s2_ep [AXES][AXES];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_ok <= s1_ok;
      for (int i = 0; i < AXES; i++) begin
        for (int j = 0; j < AXES; j++) begin
          s2_cp[i][j] <= s1_cen[i] * coef[i][j];
          s2_ep[i][j] <= s1_ext[i] * coef_mag[i][j];
        end
      end
    end
  end

  // Stage 3: per output axis sums, with the doubled translation on the center.
  logic                    s3_ok;
  logic signed [ACC_W-1:0] s3_cen [AXES];
  logic signed [ACC_W-1:0] s3_ext [AXES];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_ok <= s2_ok;
      for (int j = 0; j < AXES; j++) begin
        s3_cen[j] <= (ACC_W'(shifts[j]) <<< (COEF_FRAC + 1)) + ACC_W'(s2_cp[0][j])
                     + ACC_W'(s2_cp[1][j]) + ACC_W'(s2_cp[2][j]);
        s3_ext[j] <= $signed(ACC_W'(s2_ep[0][j]) + ACC_W'(s2_ep[1][j])
                     + ACC_W'(s2_ep[2][j]));
      end
    end
  end

  // Stage 4: corners, floor shift and saturation into the output register.
  logic signed [ACC_W-1:0]       lo_val  [AXES];
  logic signed [ACC_W-1:0]       hi_val  [AXES];
  logic signed [COORD_WIDTH-1:0] lo_sat  [AXES];
  logic signed [COORD_WIDTH-1:0] hi_sat  [AXES];
  logic [AXES-1:0]               lo_clip;
  logic [AXES-1:0]               hi_clip;

  for (genvar j = 0; j < AXES; j++) begin : g_corner
    assign lo_val[j] = s3_cen[j] - s3_ext[j];
    assign hi_val[j] = s3_cen[j] + s3_ext[j];

    aat_clamp #(
      .COORD_WIDTH (COORD_WIDTH),
      .ACC_WIDTH   (ACC_W),
      .SHIFT       (COEF_FRAC + 1)
    ) u_clamp_lo (
      .value  (lo_val[j]),
      .result (lo_sat[j]),
      .clip   (lo_clip[j])
    );

    aat_clamp #(
      .COORD_WIDTH (COORD_WIDTH),
      .ACC_WIDTH   (ACC_W),
      .SHIFT       (COEF_FRAC + 1)
    ) u_clamp_hi (
      .value  (hi_val[j]),
      .result (hi_sat[j]),
      .clip   (hi_clip[j])
    );
  end

  logic                          s4_ok;
  logic                          s4_clip;
  logic signed [COORD_WIDTH-1:0] s4_lo [AXES];
  logic signed [COORD_WIDTH-1:0] s4_hi [AXES];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_ok   <= s3_ok;
      s4_clip <= s3_ok && ((|lo_clip) || (|hi_clip));
      for (int j = 0; j < AXES; j++) begin
        s4_lo[j] <= s3_ok ? lo_sat[j] : '0;
        s4_hi[j] <= s3_ok ? hi_sat[j] : '0;
      end
    end
  end

  assign bound.valid    = vld[STAGES-1];
  assign bound.out_lo_x = s4_lo[0];
  assign bound.out_lo_y = s4_lo[1];
  assign bound.out_lo_z = s4_lo[2];
  assign bound.out_hi_x = s4_hi[0];
  assign bound.out_hi_y = s4_hi[1];
  assign bound.out_hi_z = s4_hi[2];
  assign bound.out_ok   = s4_ok;
  assign bound.clipped  = s4_clip;

endmodule

>>> bench/aabb_affine_transform_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for aabb_affine_transform: directed boxes, saturation and random phases.
// Depends on aat_pkg, the aat_cfg_if, aat_box_if and aat_bound_if interfaces, and the block.

module aabb_affine_transform_tb;

  localparam int COORD_W = 24;
  localparam int COEF_W = 16;
  localparam int AXES = aat_pkg::NUM_AXES;
  localparam int IDX_W = aat_pkg::CFG_INDEX_W;
  localparam int COEF_FRAC = COEF_W - aat_pkg::COEF_INT_W;
  localparam int ROW_W = AXES * COEF_W;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 110;
  localparam longint COORD_HI = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam logic signed [COORD_W-1:0] C_MAX = COORD_W'(COORD_HI);
  localparam logic signed [COORD_W-1:0] C_MIN = COORD_W'(COORD_LO);
  localparam logic [IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

  typedef struct {
    logic signed [COORD_W-1:0] lo [AXES];
    logic signed [COORD_W-1:0] hi [AXES];
    logic                      ok;
  } box_t;

  typedef struct {
    logic signed [COORD_W-1:0] lo [AXES];
    logic signed [COORD_W-1:0] hi [AXES];
    logic                      ok;
    logic                      clipped;
  } bound_t;

  logic clk;
  logic rst;

  aat_cfg_if #(.DATA_WIDTH(ROW_W)) cfg_ch ();
  aat_box_if #(.COORD_WIDTH(COORD_W)) box_ch ();
  aat_bound_if #(.COORD_WIDTH(COORD_W)) bound_ch ();

  aabb_affine_transform #(
    .COORD_WIDTH(COORD_W),
    .COEF_WIDTH (COEF_W)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .box  (box_ch),
    .bound(bound_ch)
  );

  logic [ROW_W-1:0]          mat_rows [AXES];
  logic signed [COORD_W-1:0] offsets [AXES];
  bound_t                    pending_bounds [$];
  int                        fail_count = 0;
  bit                        src_idle_en = 1'b0;
  bit                        sink_idle_en = 1'b0;
  int                        long_hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint coef_at(logic [ROW_W-1:0] row, int j);
    logic signed [COEF_W-1:0] c;
    c = row[j*COEF_W +: COEF_W];
    return longint'(c);
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [COORD_W-1:0] saturate(longint v, inout bit clip);
    if (v > COORD_HI) begin
      clip = 1'b1;
      return C_MAX;
    end
    if (v < COORD_LO) begin
      clip = 1'b1;
      return C_MIN;
    end
    return COORD_W'(v);
  endfunction

  function automatic bound_t transform_box(box_t b);
    bound_t r;
    longint c2 [AXES];
    longint e2 [AXES];
    longint cen;
    longint ext;
    longint m;
    bit     clip;
    clip = 1'b0;
    r.ok = 1'b0;
    r.clipped = 1'b0;
    for (int j = 0; j < AXES; j++) begin
      r.lo[j] = '0;
      r.hi[j] = '0;
    end
    if (b.ok !== 1'b1) return r;
    for (int i = 0; i < AXES; i++) begin
      c2[i] = longint'(b.hi[i]) + longint'(b.lo[i]);
      e2[i] = longint'(b.hi[i]) - longint'(b.lo[i]);
    end
    // Everything is kept doubled so the final shift also drops the factor of two.
    for (int j = 0; j < AXES; j++) begin
      cen = longint'(offsets[j]) <<< (COEF_FRAC + 1);
      ext = 0;
      for (int i = 0; i < AXES; i++) begin
        m = coef_at(mat_rows[i], j);
        cen += c2[i] * m;
        ext += magnitude(e2[i]) * magnitude(m);
      end
      r.lo[j] = saturate((cen - ext) >>> (COEF_FRAC + 1), clip);
      r.hi[j] = saturate((cen + ext) >>> (COEF_FRAC + 1), clip);
    end
    r.ok = 1'b1;
    r.clipped = clip;
    return r;
  endfunction

  function automatic box_t make_box(logic signed [COORD_W-1:0] lx, ly, lz, hx, hy, hz,
                                    logic ok);
    box_t b;
    b.lo[0] = lx;
    b.lo[1] = ly;
    b.lo[2] = lz;
    b.hi[0] = hx;
    b.hi[1] = hy;
    b.hi[2] = hz;
    b.ok = ok;
    return b;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
    logic signed [COORD_W-1:0] v;
    case (mode)
      0: v = COORD_W'($urandom);
      1: v = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
      default: begin
        case ($urandom_range(0, 3))
          0: v = C_MIN;
          1: v = C_MAX;
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic box_t random_box();
    box_t                      b;
    int                        mode;
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] c;
    for (int i = 0; i < AXES; i++) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 4) ? 0 : (mode < 8) ? 1 : 2;
      a = rand_coord(mode);
      c = rand_coord(mode);
      // Mostly well-ordered corners; the rest keep min above max.
      if (a > c && $urandom_range(0, 9) != 0) begin
        b.lo[i] = c;
        b.hi[i] = a;
      end else begin
        b.lo[i] = a;
        b.hi[i] = c;
      end
    end
    b.ok = ($urandom_range(0, 99) >= 8);
    return b;
  endfunction

  function automatic logic [ROW_W-1:0] rand_row(int mode);
    logic [ROW_W-1:0]  r;
    logic [COEF_W-1:0] c;
    for (int j = 0; j < AXES; j++) begin
      case (mode)
        0: c = COEF_W'($urandom);
        1: c = COEF_W'(int'($urandom_range(0, 16384)) - 8192);
        default: begin
          case ($urandom_range(0, 4))
            0: c = 16'h8000;
            1: c = 16'h7fff;
            2: c = 16'h0000;
            3: c = 16'h1000;
            default: c = 16'hf000;
          endcase
        end
      endcase
      r[j*COEF_W +: COEF_W] = c;
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_offset(int mode);
    case (mode)
      0: return COORD_W'($urandom);
      1: return COORD_W'(int'($urandom_range(0, 8191)) - 4096);
      default: begin
        case ($urandom_range(0, 2))
          0: return C_MIN;
          1: return C_MAX;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic send_box(input box_t b);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      box_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    box_ch.valid <= 1'b1;
    box_ch.lo_x <= b.lo[0];
    box_ch.lo_y <= b.lo[1];
    box_ch.lo_z <= b.lo[2];
    box_ch.hi_x <= b.hi[0];
    box_ch.hi_y <= b.hi[1];
    box_ch.hi_z <= b.hi[2];
    box_ch.box_ok <= b.ok;
    do @(posedge clk); while (box_ch.ready !== 1'b1);
    pending_bounds.push_back(transform_box(b));
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      aat_pkg::CFG_ROW_X: mat_rows[0] = value;
      aat_pkg::CFG_ROW_Y: mat_rows[1] = value;
      aat_pkg::CFG_ROW_Z: mat_rows[2] = value;
      aat_pkg::CFG_SHIFT_X: offsets[0] = value[COORD_W-1:0];
      aat_pkg::CFG_SHIFT_Y: offsets[1] = value[COORD_W-1:0];
      aat_pkg::CFG_SHIFT_Z: offsets[2] = value[COORD_W-1:0];
      default: ;
    endcase
  endtask

  // Upper data bits of the translation writes carry junk that the block must drop.
  task automatic load_transform(input logic [ROW_W-1:0] rows [AXES],
                                input logic signed [COORD_W-1:0] shifts [AXES]);
    write_reg(aat_pkg::CFG_ROW_X, rows[0]);
    write_reg(aat_pkg::CFG_ROW_Y, rows[1]);
    write_reg(aat_pkg::CFG_ROW_Z, rows[2]);
    write_reg(aat_pkg::CFG_SHIFT_X, {COORD_W'($urandom), shifts[0]});
    write_reg(aat_pkg::CFG_SHIFT_Y, {COORD_W'($urandom), shifts[1]});
    write_reg(aat_pkg::CFG_SHIFT_Z, {COORD_W'($urandom), shifts[2]});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    box_ch.valid <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_reset_identity();
    send_box(make_box(-24'sd256, 24'sd512, -24'sd1000, 24'sd768, 24'sd4096, 24'sd3, 1'b1));
    send_box(make_box(24'sd5000, -24'sd7, 24'sd100, -24'sd300, -24'sd900, 24'sd99, 1'b1));
    send_box(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1));
    send_box(make_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1));
    send_box(make_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1));
    send_box(make_box('0, '0, '0, '0, '0, '0, 1'b1));
    send_box(make_box(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                      rand_coord(0), rand_coord(0), 1'b0));
    send_box(make_box(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 1'b0));
  endtask

  task automatic test_unused_index();
    drain();
    write_reg(IDX_UNMAPPED_LO, ROW_W'({$urandom, $urandom}));
    write_reg(IDX_UNMAPPED_HI, ROW_W'({$urandom, $urandom}));
    cfg_ch.valid <= 1'b0;
    send_box(make_box(-24'sd1, -24'sd2, -24'sd3, 24'sd1, 24'sd2, 24'sd3, 1'b1));
    send_box(random_box());
  endtask

  task automatic test_saturation();
    logic [ROW_W-1:0]          rows [AXES];
    logic signed [COORD_W-1:0] shifts [AXES];
    drain();
    rows = '{48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff};
    shifts = '{C_MAX, C_MAX, C_MAX};
    load_transform(rows, shifts);
    send_box(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1));
    send_box(make_box(24'sd10, 24'sd20, 24'sd30, 24'sd40, 24'sd50, 24'sd60, 1'b1));
    drain();
    rows = '{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000};
    shifts = '{C_MIN, C_MIN, C_MIN};
    load_transform(rows, shifts);
    send_box(make_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1));
    send_box(make_box(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 1'b1));
    drain();
    rows = '{48'h0, 48'h0, 48'h0};
    shifts = '{rand_offset(0), rand_offset(0), rand_offset(0)};
    load_transform(rows, shifts);
    send_box(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1));
    send_box(random_box());
  endtask

  task automatic test_random_phases();
    logic [ROW_W-1:0]          rows [AXES];
    logic signed [COORD_W-1:0] shifts [AXES];
    int                        mode;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      mode = p % 3;
      for (int i = 0; i < AXES; i++) begin
        rows[i] = rand_row(mode);
        shifts[i] = rand_offset((p / 3) % 3);
      end
      load_transform(rows, shifts);
      src_idle_en = (p % 3 != 2);
      sink_idle_en = (p % 4 != 3);
      repeat (PHASE_ITEMS) send_box(random_box());
    end
  endtask

  task automatic test_backpressure();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b1;
    long_hold_req = 300;
    repeat (80) send_box(random_box());
  endtask

  task automatic test_quiet_tail();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (100) send_box(random_box());
  endtask

  initial begin : receiver
    int quiet;
    quiet = 0;
    bound_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req > 0) begin
        quiet = long_hold_req;
        long_hold_req = 0;
      end else if (quiet == 0 && sink_idle_en && $urandom_range(0, 5) == 0) begin
        quiet = $urandom_range(1, 10);
      end
      if (quiet > 0) begin
        bound_ch.ready <= 1'b0;
        quiet--;
      end else begin
        bound_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic signed [COORD_W-1:0] want,
                             input logic signed [COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin : bound_checker
    bound_t want;
    forever begin
      @(posedge clk);
      if (bound_ch.valid === 1'b1 && bound_ch.ready === 1'b1) begin
        if (pending_bounds.size() == 0) begin
          $error("bound transfer with no box outstanding");
          fail_count++;
        end else begin
          want = pending_bounds.pop_front();
          check_field("out_lo_x", want.lo[0], bound_ch.out_lo_x);
          check_field("out_lo_y", want.lo[1], bound_ch.out_lo_y);
          check_field("out_lo_z", want.lo[2], bound_ch.out_lo_z);
          check_field("out_hi_x", want.hi[0], bound_ch.out_hi_x);
          check_field("out_hi_y", want.hi[1], bound_ch.out_hi_y);
          check_field("out_hi_z", want.hi[2], bound_ch.out_hi_z);
          check_field("out_ok", COORD_W'(want.ok), COORD_W'(bound_ch.out_ok));
          check_field("clipped", COORD_W'(want.clipped), COORD_W'(bound_ch.clipped));
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((box_ch.valid === 1'b1 && box_ch.ready === 1'b1) ||
          (bound_ch.valid === 1'b1 && bound_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("aabb_affine_transform: mismatch");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    box_ch.valid <= 1'b0;
    box_ch.lo_x <= '0;
    box_ch.lo_y <= '0;
    box_ch.lo_z <= '0;
    box_ch.hi_x <= '0;
    box_ch.hi_y <= '0;
    box_ch.hi_z <= '0;
    box_ch.box_ok <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    for (int i = 0; i < AXES; i++) begin
      mat_rows[i] = ROW_W'(longint'(1) << COEF_FRAC) << (i * COEF_W);
      offsets[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_identity();
    test_unused_index();
    test_saturation();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    test_random_phases();
    test_backpressure();
    test_quiet_tail();
    drain();
    if (fail_count == 0) begin
      $display("aabb_affine_transform: match");
    end else begin
      $display("aabb_affine_transform: mismatch");
    end
    $finish;
  end

endmodule
